/* rtl/mpc_equality_matvec_core_defines.svh */
// Assertion macros shared by the equality matrix-vector core.
`ifndef MPC_EQUALITY_MATVEC_CORE_DEFINES_SVH
`define MPC_EQUALITY_MATVEC_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mpc_eqmv_pkg.sv */
// Types, widths and fixed-point helpers for the equality matrix-vector core.
`default_nettype none

package mpc_eqmv_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int RND_BITS  = PROD_BITS - FRAC_BITS;
  // Five terms at most are summed, so three guard bits cover every carry.
  localparam int SUM_BITS  = RND_BITS + 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [RND_BITS-1:0]  rnd_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  localparam prod_t ROUND_HALF = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic  axis;
    logic  first_step;
    word_t cur_state_0;
    word_t cur_state_1;
    word_t cur_state_2;
    word_t control_value;
    word_t coef_a3;
    word_t coef_a6;
    word_t coef_b0;
    word_t coef_b1;
    word_t coef_b2;
  } in_item_t;

  typedef struct packed {
    word_t out_0;
    word_t out_1;
    word_t out_2;
  } out_item_t;

  // Exact signed product; both operands are sign-extended to the result width.
  function automatic prod_t mul_full(input word_t a, input word_t b);
    prod_t pa;
    prod_t pb;
    pa = prod_t'(a);
    pb = prod_t'(b);
    mul_full = pa * pb;
  endfunction

  // Drop the fraction bits, rounding to nearest with halves toward plus infinity.
  // The product magnitude never exceeds 2^(2*WORD_BITS-2), so the add cannot wrap.
  function automatic rnd_t round_q(input prod_t p);
    prod_t t;
    t = p + ROUND_HALF;
    round_q = t[PROD_BITS-1:FRAC_BITS];
  endfunction

  function automatic word_t saturate(input sum_t v);
    if (v > sum_t'(WORD_MAX)) begin
      saturate = WORD_MAX;
    end else if (v < sum_t'(WORD_MIN)) begin
      saturate = WORD_MIN;
    end else begin
      saturate = v[WORD_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/mpc_equality_matvec_core.sv */
// Top level of the equality matrix-vector core: state rows minus current states plus B*u
// and, after the first step, the A matrix times the axis's previous states. It takes one
// transfer per clock while the output is not stalled and returns one result per item, in
// order. The path has three register stages: the input register, the product register
// behind the six 32x32 multipliers, and the result register after rounding, the sum and
// saturation. Each axis keeps its last state triple in flip-flops that reset clears to
// zero; the triple is read and replaced at the input transfer, so items of the same axis
// may follow each other in every cycle.
`default_nettype none
`include "mpc_equality_matvec_core_defines.svh"

module mpc_equality_matvec_core
  import mpc_eqmv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef struct packed {
    word_t x0, x1, x2;
    word_t u;
    word_t a3, a6;
    word_t b0, b1, b2;
    word_t p0, p1, p2;
  } operand_t;

  typedef struct packed {
    word_t x0, x1, x2;
    word_t p0, p1, p2;
    prod_t bu0, bu1, bu2;
    prod_t a3p1, a3p2, a6p2;
  } product_t;

  word_t     prev_r [2][3];
  logic      v1_r, v2_r, out_valid_r;
  operand_t  s1_r, s1_nxt;
  product_t  s2_r, s2_nxt;
  out_item_t out_r, out_nxt;
  logic      adv3, adv2, ld1, in_xfer;
  sum_t      sum0, sum1, sum2;

  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign ld1      = !v1_r || adv2;
  assign in_stall = !ld1;
  assign in_xfer  = in_valid && !in_stall;

  // The first step of an axis sees zero previous states, which drops every A term.
  always_comb begin
    s1_nxt.x0 = in_data.cur_state_0;
    s1_nxt.x1 = in_data.cur_state_1;
    s1_nxt.x2 = in_data.cur_state_2;
    s1_nxt.u  = in_data.control_value;
    s1_nxt.a3 = in_data.coef_a3;
    s1_nxt.a6 = in_data.coef_a6;
    s1_nxt.b0 = in_data.coef_b0;
    s1_nxt.b1 = in_data.coef_b1;
    s1_nxt.b2 = in_data.coef_b2;
    s1_nxt.p0 = in_data.first_step ? '0 : prev_r[in_data.axis][0];
    s1_nxt.p1 = in_data.first_step ? '0 : prev_r[in_data.axis][1];
    s1_nxt.p2 = in_data.first_step ? '0 : prev_r[in_data.axis][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 3; k++) begin
          prev_r[a][k] <= '0;
        end
      end
    end else if (in_xfer) begin
      prev_r[in_data.axis][0] <= in_data.cur_state_0;
      prev_r[in_data.axis][1] <= in_data.cur_state_1;
      prev_r[in_data.axis][2] <= in_data.cur_state_2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    s2_nxt.x0   = s1_r.x0;
    s2_nxt.x1   = s1_r.x1;
    s2_nxt.x2   = s1_r.x2;
    s2_nxt.p0   = s1_r.p0;
    s2_nxt.p1   = s1_r.p1;
    s2_nxt.p2   = s1_r.p2;
    s2_nxt.bu0  = mul_full(s1_r.b0, s1_r.u);
    s2_nxt.bu1  = mul_full(s1_r.b1, s1_r.u);
    s2_nxt.bu2  = mul_full(s1_r.b2, s1_r.u);
    s2_nxt.a3p1 = mul_full(s1_r.a3, s1_r.p1);
    s2_nxt.a3p2 = mul_full(s1_r.a3, s1_r.p2);
    s2_nxt.a6p2 = mul_full(s1_r.a6, s1_r.p2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  always_comb begin
    sum0 = sum_t'(s2_r.p0) - sum_t'(s2_r.x0) + sum_t'(round_q(s2_r.bu0))
         + sum_t'(round_q(s2_r.a3p1)) + sum_t'(round_q(s2_r.a6p2));
    sum1 = sum_t'(s2_r.p1) - sum_t'(s2_r.x1) + sum_t'(round_q(s2_r.bu1))
         + sum_t'(round_q(s2_r.a3p2));
    sum2 = sum_t'(s2_r.p2) - sum_t'(s2_r.x2) + sum_t'(round_q(s2_r.bu2));
    out_nxt.out_0 = saturate(sum0);
    out_nxt.out_1 = saturate(sum1);
    out_nxt.out_2 = saturate(sum2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MPC_ASSERT_NEXT(a_prev_update, in_xfer, prev_r[$past(in_data.axis)][0] == $past(in_data.cur_state_0), "previous state not replaced by transfer")
  `MPC_ASSERT_NOW(a_full_stall, v1_r && v2_r && out_valid_r && out_stall, in_stall, "input taken while pipeline is full and stalled")
  `MPC_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(v2_r), "result appeared without a product stage item")

endmodule

`default_nettype wire

/* test/mpc_equality_matvec_core_tb.sv */
// Self-checking testbench for mpc_equality_matvec_core with random idling on both sides.
`timescale 1ns / 1ps

module mpc_equality_matvec_core_tb;
  import mpc_eqmv_pkg::*;

  localparam int RANDOM_ITEMS = 1180;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;

  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t HALF = 32'sh0000_8000;
  localparam logic signed [63:0] ROW_HI = 64'(WORD_MAX);
  localparam logic signed [63:0] ROW_LO = 64'(WORD_MIN);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  in_item_t item_queue[$];
  out_item_t expected_rows[$];
  word_t prev_triple[2][3];

  int total_items = 0;
  int items_accepted = 0;
  int error_count = 0;
  int send_idle = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  mpc_equality_matvec_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round(a * b / 2^FRAC_BITS) with halves going toward plus infinity.
  function automatic logic signed [63:0] scaled_product(input word_t a, input word_t b);
    logic signed [63:0] wide_a;
    logic signed [63:0] wide_b;
    wide_a = 64'(a);
    wide_b = 64'(b);
    scaled_product = (wide_a * wide_b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic word_t clamp_word(input logic signed [63:0] v);
    if (v > ROW_HI) begin
      clamp_word = WORD_MAX;
    end else if (v < ROW_LO) begin
      clamp_word = WORD_MIN;
    end else begin
      clamp_word = v[WORD_BITS-1:0];
    end
  endfunction

  // Computes the three constraint rows of one transfer and updates that axis's history.
  function automatic void predict_rows(input in_item_t it);
    word_t cur[3];
    word_t gain[3];
    word_t prv[3];
    logic signed [63:0] cur_w;
    logic signed [63:0] prv_w[3];
    logic signed [63:0] acc[3];
    out_item_t rows;
    int ax;
    ax = int'(it.axis);
    cur[0] = it.cur_state_0;
    cur[1] = it.cur_state_1;
    cur[2] = it.cur_state_2;
    gain[0] = it.coef_b0;
    gain[1] = it.coef_b1;
    gain[2] = it.coef_b2;
    for (int r = 0; r < 3; r++) begin
      prv[r] = prev_triple[ax][r];
      prv_w[r] = 64'(prv[r]);
      cur_w = 64'(cur[r]);
      acc[r] = scaled_product(gain[r], it.control_value) - cur_w;
    end
    if (!it.first_step) begin
      acc[0] = acc[0] + prv_w[0] + scaled_product(it.coef_a3, prv[1])
               + scaled_product(it.coef_a6, prv[2]);
      acc[1] = acc[1] + prv_w[1] + scaled_product(it.coef_a3, prv[2]);
      acc[2] = acc[2] + prv_w[2];
    end
    rows.out_0 = clamp_word(acc[0]);
    rows.out_1 = clamp_word(acc[1]);
    rows.out_2 = clamp_word(acc[2]);
    expected_rows.push_back(rows);
    for (int r = 0; r < 3; r++) begin
      prev_triple[ax][r] = cur[r];
    end
  endfunction

  function automatic in_item_t make_item(input logic ax, input logic first,
                                         input word_t x0, input word_t x1, input word_t x2,
                                         input word_t u, input word_t a3, input word_t a6,
                                         input word_t b0, input word_t b1, input word_t b2);
    in_item_t it;
    it.axis = ax;
    it.first_step = first;
    it.cur_state_0 = x0;
    it.cur_state_1 = x1;
    it.cur_state_2 = x2;
    it.control_value = u;
    it.coef_a3 = a3;
    it.coef_a6 = a6;
    it.coef_b0 = b0;
    it.coef_b1 = b1;
    it.coef_b2 = b2;
    make_item = it;
  endfunction

  // Realistic magnitudes around a few units, with extremes and, most often, raw words mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: rand_word = WORD_MAX;
      1: rand_word = WORD_MIN;
      2: rand_word = '0;
      3, 4, 5: rand_word = word_t'($urandom_range(0, 1 << 20)) - word_t'(1 << 19);
      default: rand_word = word_t'($urandom);
    endcase
  endfunction

  // Idling pauses in every third block of transfers and for the whole tail of the run.
  function automatic bit quiet_phase();
    quiet_phase = (items_accepted >= total_items - TAIL_ITEMS) ||
                  ((items_accepted / 96) % 3 == 2);
  endfunction

  initial begin
    bit axis_live[2];
    logic ax;
    logic first;
    axis_live[0] = 1'b0;
    axis_live[1] = 1'b0;
    for (int a = 0; a < 2; a++) begin
      for (int r = 0; r < 3; r++) begin
        prev_triple[a][r] = '0;
      end
    end

    // Axis 1 and then axis 0 continue a step that never had a predecessor.
    item_queue.push_back(make_item(1'b1, 1'b0, ONE, -ONE, 3 * ONE, ONE, HALF, ONE,
                                   ONE, -ONE, HALF));
    item_queue.push_back(make_item(1'b0, 1'b0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    item_queue.push_back(make_item(1'b0, 1'b0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                   WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
    item_queue.push_back(make_item(1'b0, 1'b0, '0, '0, '0, '0, WORD_MIN, WORD_MIN,
                                   '0, '0, '0));
    // Negating the most negative state overflows; one above it just fits.
    item_queue.push_back(make_item(1'b0, 1'b1, WORD_MIN, -WORD_MAX, WORD_MAX, '0,
                                   '0, '0, '0, '0, '0));
    // Products that land exactly on a half.
    item_queue.push_back(make_item(1'b1, 1'b1, '0, '0, '0, HALF, '0, '0,
                                   32'sd1, -32'sd1, -32'sd3));
    item_queue.push_back(make_item(1'b1, 1'b1, '0, '0, '0, -HALF, '0, '0,
                                   32'sd1, 32'sd3, -32'sd1));
    item_queue.push_back(make_item(1'b1, 1'b1, ONE, HALF, 32'sd3, '0, '0, '0,
                                   '0, '0, '0));
    item_queue.push_back(make_item(1'b1, 1'b0, '0, '0, '0, '0, HALF, 32'sd1,
                                   '0, '0, '0));
    item_queue.push_back(make_item(1'b0, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    item_queue.push_back(make_item(1'b1, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    item_queue.push_back(make_item(1'b1, 1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    item_queue.push_back(make_item(1'b1, 1'b0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                   WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    item_queue.push_back(make_item(1'b1, 1'b0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    item_queue.push_back(make_item(1'b0, 1'b0, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE,
                                   -ONE, -ONE, -ONE));
    item_queue.push_back(make_item(1'b0, 1'b0, 2 * ONE, -HALF, 5 * ONE, 3 * HALF,
                                   ONE / 10, ONE / 200, ONE / 50, ONE / 10, ONE));
    item_queue.push_back(make_item(1'b0, 1'b0, ONE, ONE, ONE, '0, ONE, ONE,
                                   '0, '0, '0));

    // Random part: mostly per-axis trajectories, with raw noise and restarts mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      ax = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        item_queue.push_back(make_item(ax, 1'($urandom_range(0, 1)), $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom));
      end else begin
        first = !axis_live[ax] || ($urandom_range(0, 19) == 0);
        axis_live[ax] = 1'b1;
        item_queue.push_back(make_item(ax, first, rand_word(), rand_word(), rand_word(),
                                       rand_word(), rand_word(), rand_word(),
                                       rand_word(), rand_word(), rand_word()));
      end
    end
    total_items = item_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(items_accepted == total_items && expected_rows.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("mpc_equality_matvec_core test passed");
    end else begin
      $display("mpc_equality_matvec_core test failed");
    end
    $finish;
  end

  // Sender: a stalled payload is held; otherwise the next item or an idle burst is chosen.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_idle <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rows(in_data);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0) begin
          in_valid <= 1'b0;
          send_idle <= send_idle - 1;
        end else if (item_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_idle <= $urandom_range(0, 7);
        end else begin
          in_data <= item_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AT) begin
      out_stall <= 1'b1;
      stall_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_phase() && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    word_t got[3];
    word_t want[3];
    out_item_t rows;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, out_data);
        error_count++;
      end else begin
        rows = expected_rows.pop_front();
        want[0] = rows.out_0;
        want[1] = rows.out_1;
        want[2] = rows.out_2;
        got[0] = out_data.out_0;
        got[1] = out_data.out_1;
        got[2] = out_data.out_2;
        for (int r = 0; r < 3; r++) begin
          if (got[r] !== want[r]) begin
            $display("%0t: row %0d mismatch, expected %0d, actual %0d",
                     $time, r, want[r], got[r]);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mpc_equality_matvec_core test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mpc_eqmv_pkg.sv
rtl/mpc_equality_matvec_core.sv
test/mpc_equality_matvec_core_tb.sv
